// File: src/lcg48_pkg.sv
// shared types and constants for the 48-bit lcg generator
`timescale 1ns / 1ps

package lcg48_pkg;

   localparam int STATE_W  = 48;
   localparam int MULT_W   = 35;
   localparam int DRAW31_W = 31;
   localparam int VALUE_W  = 64;
   localparam int TYPE_W   = 3;
   localparam int COUNT_W  = 6;

   localparam logic [MULT_W-1:0]  LCG_MULT   = 35'h5_DEEC_E66D;
   localparam logic [STATE_W-1:0] LCG_MULT48 = {13'd0, LCG_MULT};
   localparam logic [STATE_W-1:0] LCG_INC    = 48'hB;

   // request codes
   localparam logic [TYPE_W-1:0] REQ_RESEED    = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_NEXT_BITS = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_BOUNDED   = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_LONG      = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_FLOAT     = 3'd4;
   localparam logic [TYPE_W-1:0] REQ_DOUBLE    = 3'd5;

   typedef struct packed {
      logic               done;
      logic [STATE_W-1:0] state;
   } step_out_type;

   typedef struct packed {
      logic                go;
      logic [DRAW31_W-1:0] dividend;
      logic [DRAW31_W-1:0] divisor;
   } div_in_type;

   typedef struct packed {
      logic                done;
      logic [DRAW31_W-1:0] rem;
   } div_out_type;

endpackage

// File: src/lcg48_ifs.sv
// request and response channel interfaces of the lcg generator
`timescale 1ns / 1ps

interface lcg48_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         req_type;
   logic signed [63:0] seed_value;
   logic [5:0]         bit_count;
   logic [30:0]        bound;

   modport source (output valid, req_type, seed_value, bit_count, bound, input ready);
   modport sink (input valid, req_type, seed_value, bit_count, bound, output ready);
endinterface

interface lcg48_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] value;

   modport source (output valid, value, input ready);
   modport sink (input valid, value, output ready);
endinterface

// File: src/lcg48_step.sv
// one lcg step: state * multiplier + increment, 16 state bits per cycle
`timescale 1ns / 1ps

module lcg48_step (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  logic [lcg48_pkg::STATE_W-1:0] state_src,
   output lcg48_pkg::step_out_type       step_out
);
   import lcg48_pkg::*;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [1:0]         phase_ff, phase_in;
   logic [STATE_W-1:0] src_ff, src_in;
   logic [STATE_W-1:0] prod_ff, prod_in;
   logic [STATE_W-1:0] acc_ff, acc_in;
   logic [15:0]        chunk;
   logic [50:0]        mul_full;

   always_comb begin
      case (phase_ff)
         2'd0:    chunk = src_ff[15:0];
         2'd1:    chunk = src_ff[31:16];
         default: chunk = src_ff[47:32];
      endcase
      mul_full = 51'(chunk) * 51'(LCG_MULT);
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      phase_in = phase_ff;
      src_in   = src_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      if (go) begin
         busy_in  = 1'b1;
         phase_in = 2'd0;
         src_in   = state_src;
         acc_in   = LCG_INC;
      end else if (busy_ff) begin
         phase_in = phase_ff + 2'd1;
         // partial products land in the cycle after they are formed
         if (phase_ff != 2'd0) begin
            acc_in = acc_ff + prod_ff;
         end
         case (phase_ff)
            2'd0:    prod_in = mul_full[47:0];
            2'd1:    prod_in = {mul_full[31:0], 16'd0};
            2'd2:    prod_in = {mul_full[15:0], 32'd0};
            default: prod_in = '0;
         endcase
         if (phase_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= 2'd0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
      end
      src_ff  <= src_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign step_out.done  = done_ff;
   assign step_out.state = acc_ff;

endmodule

// File: src/lcg48_div.sv
// restoring remainder unit, one quotient bit per cycle
`timescale 1ns / 1ps

module lcg48_div (
   input  logic                   clock,
   input  logic                   reset,
   input  lcg48_pkg::div_in_type  div_in,
   output lcg48_pkg::div_out_type div_out
);
   import lcg48_pkg::*;

   localparam int CNT_W = $clog2(DRAW31_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DRAW31_W-1:0] dvd_ff, dvd_in;
   logic [DRAW31_W-1:0] dsr_ff, dsr_in;
   logic [DRAW31_W-1:0] rem_ff, rem_in;
   logic [DRAW31_W:0]   trial;

   assign trial = {rem_ff, dvd_ff[DRAW31_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (div_in.go) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DRAW31_W - 1);
         dvd_in  = div_in.dividend;
         dsr_in  = div_in.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DRAW31_W-2:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = DRAW31_W'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = trial[DRAW31_W-1:0];
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign div_out.done = done_ff;
   assign div_out.rem  = rem_ff;

endmodule

// File: src/lcg48_random_generator.sv
// top level of the 48-bit lcg random generator with its request sequencer
//
//  channel   dir  handshake            payload
//  req_chan  in   valid/ready          req_type, seed_value, bit_count, bound
//  rsp_chan  out  valid/ready          value (one per request)
//
// one request at a time; req_chan.ready is high only while the sequencer is idle
// each lcg step runs in the shared 16x35 multiplier slice unit
// bounded int: multiply path for a power-of-two bound, else a remainder-unit pass per draw attempt,
//   repeated while the rejection test fails
// synchronous reset loads the state as seeded with zero; a stalled rsp_chan holds
//   the finished value in the output register while the next request is taken
`timescale 1ns / 1ps

module lcg48_random_generator (
   input logic clock,
   input logic reset,
   lcg48_req_if.sink   req_chan,
   lcg48_rsp_if.source rsp_chan
);
   import lcg48_pkg::*;

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_STEP   = 3'd1;
   localparam logic [2:0] S_MUL    = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [STATE_W-1:0]  lcg_state_ff, lcg_state_in;
   logic [TYPE_W-1:0]   type_ff, type_in;
   logic [COUNT_W-1:0]  nbits_ff, nbits_in;
   logic [DRAW31_W-1:0] bound_ff, bound_in;
   logic [DRAW31_W-1:0] d_ff, d_in;
   logic [31:0]         first_ff, first_in;
   logic                draw2_ff, draw2_in;
   logic [VALUE_W-1:0]  result_ff, result_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;

   logic               req_accept;
   logic               step_go;
   logic [STATE_W-1:0] step_src;
   step_out_type       step_out;
   div_in_type         div_in;
   div_out_type        div_out;

   logic [31:0]              top32;
   logic [5:0]               nb_sat;
   logic [4:0]               bits_shift;
   logic [31:0]              bits_val;
   logic                     bound_pow2;
   logic [2*DRAW31_W-1:0]    mul_prod;
   logic [31:0]              reject_sum;
   logic                     out_load;

   lcg48_step u_step (
      .clock     (clock),
      .reset     (reset),
      .go        (step_go),
      .state_src (step_src),
      .step_out  (step_out)
   );

   lcg48_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_in  (div_in),
      .div_out (div_out)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;

   // top bit_count bits of the fresh state, saturated at 32
   assign top32 = step_out.state[47:16];
   always_comb begin
      nb_sat     = (nbits_ff > 6'd32) ? 6'd32 : nbits_ff;
      bits_shift = 5'(6'd32 - nb_sat);
      bits_val   = (nb_sat == 6'd0) ? 32'd0 : (top32 >> bits_shift);
   end

   assign bound_pow2 = ((bound_ff & (~bound_ff + 31'd1)) == bound_ff);
   assign mul_prod   = (2*DRAW31_W)'(d_ff) * (2*DRAW31_W)'(bound_ff);
   // rejection when d - r + (bound - 1) overflows a signed 32-bit int
   assign reject_sum = 32'(d_ff) - 32'(div_out.rem) + 32'(bound_ff) - 32'd1;
   assign out_load   = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in        = state_ff;
      lcg_state_in    = lcg_state_ff;
      type_in         = type_ff;
      nbits_in        = nbits_ff;
      bound_in        = bound_ff;
      d_in            = d_ff;
      first_in        = first_ff;
      draw2_in        = draw2_ff;
      result_in       = result_ff;
      step_go         = 1'b0;
      step_src        = lcg_state_ff;
      div_in.go       = 1'b0;
      div_in.dividend = step_out.state[47:17];
      div_in.divisor  = bound_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               type_in  = req_chan.req_type;
               nbits_in = req_chan.bit_count;
               bound_in = req_chan.bound;
               draw2_in = 1'b0;
               unique case (req_chan.req_type) inside
                  REQ_RESEED: begin
                     lcg_state_in = req_chan.seed_value[STATE_W-1:0] ^ LCG_MULT48;
                     result_in    = '0;
                     state_in     = S_FINISH;
                  end
                  REQ_NEXT_BITS, REQ_LONG, REQ_FLOAT, REQ_DOUBLE: begin
                     step_go  = 1'b1;
                     state_in = S_STEP;
                  end
                  REQ_BOUNDED: begin
                     // zero bound draws nothing
                     if (req_chan.bound == '0) begin
                        result_in = '0;
                        state_in  = S_FINISH;
                     end else begin
                        step_go  = 1'b1;
                        state_in = S_STEP;
                     end
                  end
                  default: begin
                     result_in = '0;
                     state_in  = S_FINISH;
                  end
               endcase
            end
         end

         S_STEP: begin
            if (step_out.done) begin
               lcg_state_in = step_out.state;
               unique case (type_ff) inside
                  REQ_NEXT_BITS: begin
                     result_in = {{32{bits_val[31]}}, bits_val};
                     state_in  = S_FINISH;
                  end
                  REQ_FLOAT: begin
                     result_in = {40'd0, step_out.state[47:24]};
                     state_in  = S_FINISH;
                  end
                  REQ_LONG: begin
                     if (!draw2_ff) begin
                        first_in = top32;
                        draw2_in = 1'b1;
                        step_go  = 1'b1;
                        step_src = step_out.state;
                     end else begin
                        result_in = {first_ff, 32'd0} + {{32{top32[31]}}, top32};
                        state_in  = S_FINISH;
                     end
                  end
                  REQ_DOUBLE: begin
                     if (!draw2_ff) begin
                        first_in = {6'd0, step_out.state[47:22]};
                        draw2_in = 1'b1;
                        step_go  = 1'b1;
                        step_src = step_out.state;
                     end else begin
                        result_in = {11'd0, first_ff[25:0], step_out.state[47:21]};
                        state_in  = S_FINISH;
                     end
                  end
                  REQ_BOUNDED: begin
                     d_in = step_out.state[47:17];
                     if (bound_pow2) begin
                        state_in = S_MUL;
                     end else begin
                        div_in.go = 1'b1;
                        state_in  = S_DIV;
                     end
                  end
                  default: begin
                     result_in = '0;
                     state_in  = S_FINISH;
                  end
               endcase
            end
         end

         S_MUL: begin
            result_in = {33'd0, mul_prod[2*DRAW31_W-1:DRAW31_W]};
            state_in  = S_FINISH;
         end

         S_DIV: begin
            if (div_out.done) begin
               if (reject_sum[31]) begin
                  step_go  = 1'b1;
                  state_in = S_STEP;
               end else begin
                  result_in = {33'd0, div_out.rem};
                  state_in  = S_FINISH;
               end
            end
         end

         S_FINISH: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in = rsp_value_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = result_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lcg_state_ff <= LCG_MULT48;
         rsp_valid_ff <= 1'b0;
         draw2_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lcg_state_ff <= lcg_state_in;
         rsp_valid_ff <= rsp_valid_in;
         draw2_ff     <= draw2_in;
      end
      type_ff      <= type_in;
      nbits_ff     <= nbits_in;
      bound_ff     <= bound_in;
      d_ff         <= d_in;
      first_ff     <= first_in;
      result_ff    <= result_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.value = rsp_value_ff;

   // a reseed transaction loads the masked seed xor multiplier
   a_reseed_load: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_chan.req_type == REQ_RESEED) |=>
         lcg_state_ff == ($past(req_chan.seed_value[STATE_W-1:0]) ^ LCG_MULT48))
      else $error("reseed did not load the state");

   // the step unit only finishes while the sequencer waits on it
   a_step_done_state: assert property (@(posedge clock) disable iff (reset)
      step_out.done |-> state_ff == S_STEP)
      else $error("step unit finished outside the step state");

   // the remainder unit only finishes while the sequencer waits on it
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_out.done |-> state_ff == S_DIV)
      else $error("remainder unit finished outside the divide state");

   // a bounded draw stays below its bound
   a_bounded_range: assert property (@(posedge clock) disable iff (reset)
      out_load && (type_ff == REQ_BOUNDED) && (bound_ff != '0) |->
         result_ff < {33'd0, bound_ff})
      else $error("bounded draw out of range");

endmodule

// File: dv/lcg48_random_generator_test.sv
// self-checking testbench for the 48-bit lcg random generator
`timescale 1ns / 1ps

module lcg48_random_generator_test;
   import lcg48_pkg::*;

   // request codes the block ignores
   localparam logic [TYPE_W-1:0] REQ_SPARE6 = 3'd6;
   localparam logic [TYPE_W-1:0] REQ_SPARE7 = 3'd7;

   localparam int BUSY_COUNT   = 500;    // random requests with idling on both sides
   localparam int CALM_COUNT   = 100;    // closing random requests, no idling
   localparam int STALL_LIMIT  = 20000;  // cycles with work outstanding and no transaction
   localparam int DRAIN_CYCLES = 64;     // a little over the longest single draw attempt
   localparam int MAX_REPORTS  = 10;

   typedef struct {
      logic [TYPE_W-1:0]   kind;
      logic [VALUE_W-1:0]  seed;
      logic [COUNT_W-1:0]  count;
      logic [DRAW31_W-1:0] bound;
   } draw_request_type;

   logic clock;
   logic reset;

   lcg48_req_if req_if ();
   lcg48_rsp_if rsp_if ();

   lcg48_random_generator dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // stimulus waiting to be driven and draws waiting to come back
   draw_request_type   pending_requests [$];
   logic [VALUE_W-1:0] expected_values [$];

   // shadow copy of the generator state
   logic [STATE_W-1:0] model_state;

   bit          idling_on = 1'b1;
   int          failures;
   int          results_checked;
   int          redraws;
   int          quiet_cycles;
   int          kind_hits [8];
   int unsigned send_gap, send_odds;
   int unsigned take_gap, take_odds;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------------------
   // shadow generator
   // ---------------------------------------------------------------------------

   // one lcg step, then the top nbits of the new state (0 gives 0, above 32 saturates)
   function automatic logic [31:0] step_top_bits(input int unsigned nbits);
      int unsigned n;
      n = (nbits > 32) ? 32 : nbits;
      model_state = model_state * LCG_MULT48 + LCG_INC;
      if (n == 0)
         return 32'd0;
      return 32'(model_state >> (STATE_W - n));
   endfunction

   // uniform draw in 0..limit-1; multiply path for powers of two, else modulo with rejection
   function automatic logic [VALUE_W-1:0] draw_below(input logic [DRAW31_W-1:0] limit);
      logic [31:0] n;
      logic [31:0] d;
      logic [31:0] r;
      logic [63:0] scaled;
      n = {1'b0, limit};
      if (n == 32'd0)
         return '0;
      if ((n & (~n + 32'd1)) == n) begin
         scaled = 64'(step_top_bits(31)) * 64'(n);
         return scaled >> 31;
      end
      d = step_top_bits(31);
      r = d % n;
      // the remainder is thrown away when the 32-bit sum wraps into the sign bit
      while (((d - r + (n - 32'd1)) & 32'h8000_0000) != 32'd0) begin
         redraws++;
         d = step_top_bits(31);
         r = d % n;
      end
      return 64'(r);
   endfunction

   function automatic logic [VALUE_W-1:0] predict_draw(input draw_request_type rq);
      logic [31:0] hi;
      logic [31:0] lo;
      case (rq.kind)
         REQ_RESEED: begin
            model_state = rq.seed[STATE_W-1:0] ^ LCG_MULT48;
            return '0;
         end
         REQ_NEXT_BITS: begin
            lo = step_top_bits(rq.count);
            return {{32{lo[31]}}, lo};
         end
         REQ_BOUNDED:
            return draw_below(rq.bound);
         REQ_LONG: begin
            hi = step_top_bits(32);
            lo = step_top_bits(32);
            return {hi, 32'd0} + {{32{lo[31]}}, lo};
         end
         REQ_FLOAT:
            return 64'(step_top_bits(24));
         REQ_DOUBLE: begin
            hi = step_top_bits(26);
            lo = step_top_bits(27);
            return (64'(hi) << 27) + 64'(lo);
         end
         default:
            return '0;
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------

   function automatic logic [VALUE_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic draw_request_type make_request(input logic [TYPE_W-1:0] kind,
                                                      input logic [VALUE_W-1:0] seed,
                                                      input logic [COUNT_W-1:0] count,
                                                      input logic [DRAW31_W-1:0] bound);
      draw_request_type rq;
      rq.kind  = kind;
      rq.seed  = seed;
      rq.count = count;
      rq.bound = bound;
      return rq;
   endfunction

   // every field random, so unused fields carry junk that must be ignored
   function automatic draw_request_type random_request();
      draw_request_type rq;
      int unsigned      pick;
      pick = $urandom_range(0, 99);
      if (pick < 8)
         rq.kind = REQ_RESEED;
      else if (pick < 30)
         rq.kind = REQ_NEXT_BITS;
      else if (pick < 60)
         rq.kind = REQ_BOUNDED;
      else if (pick < 70)
         rq.kind = REQ_LONG;
      else if (pick < 80)
         rq.kind = REQ_FLOAT;
      else if (pick < 94)
         rq.kind = REQ_DOUBLE;
      else
         rq.kind = $urandom_range(0, 1) ? REQ_SPARE6 : REQ_SPARE7;
      rq.seed = rand64();
      // mostly legal counts, sometimes zero or past the saturation point
      if ($urandom_range(0, 4) != 0)
         rq.count = 6'($urandom_range(1, 32));
      else
         rq.count = 6'($urandom_range(0, 63));
      pick = $urandom_range(0, 49);
      if (pick == 0)
         rq.bound = '0;
      else if (pick < 10)
         rq.bound = 31'(32'd1 << $urandom_range(0, 30));
      else if (pick < 20)
         rq.bound = 31'($urandom_range(1, 100));
      else if (pick < 32)
         // upper half, where the rejection test fires often
         rq.bound = 31'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF));
      else
         rq.bound = 31'($urandom);
      return rq;
   endfunction

   task automatic wait_for_drain();
      while (pending_requests.size() != 0 || req_if.valid || expected_values.size() != 0)
         @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // request driver: predicts each accepted transaction, then offers the next one
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         model_state = LCG_MULT48;   // same as seeding with zero
         send_gap = 0;
         send_odds = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_values.push_back(predict_draw(make_request(req_if.req_type,
               req_if.seed_value, req_if.bit_count, req_if.bound)));
            kind_hits[req_if.req_type]++;
         end
         // idling density changes now and then; zero odds make calm stretches
         if ($urandom_range(0, 63) == 0)
            send_odds = $urandom_range(0, 3);
         // a valid once raised stays up until its transaction is taken
         if (!req_if.valid || req_if.ready) begin
            if (send_gap == 0 && idling_on && $urandom_range(0, 15) < send_odds)
               send_gap = $urandom_range(1, 12);
            if (send_gap > 0) begin
               req_if.valid <= 1'b0;
               send_gap--;
            end else if (pending_requests.size() > 0) begin
               draw_request_type rq;
               rq = pending_requests.pop_front();
               req_if.valid      <= 1'b1;
               req_if.req_type   <= rq.kind;
               req_if.seed_value <= rq.seed;
               req_if.bit_count  <= rq.count;
               req_if.bound      <= rq.bound;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // response monitor: checks each transaction against the oldest prediction
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         take_gap = 0;
         take_odds = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_values.size() == 0) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $display("unexpected response: value %h with nothing outstanding",
                           rsp_if.value);
            end else begin
               logic [VALUE_W-1:0] want;
               want = expected_values.pop_front();
               results_checked++;
               if (rsp_if.value !== want) begin
                  failures++;
                  if (failures <= MAX_REPORTS)
                     $display("value mismatch on response %0d: expected %h, got %h",
                              results_checked, want, rsp_if.value);
               end
            end
         end
         if ($urandom_range(0, 63) == 0)
            take_odds = $urandom_range(0, 3);
         // back-pressure bursts; a stall may land on any cycle of the draw
         if (take_gap == 0 && idling_on && $urandom_range(0, 15) < take_odds)
            take_gap = $urandom_range(1, 12);
         if (take_gap > 0) begin
            rsp_if.ready <= 1'b0;
            take_gap--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // watchdog: only counts while work is outstanding
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (pending_requests.size() == 0 && !req_if.valid && expected_values.size() == 0)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d responses outstanding",
                     STALL_LIMIT, expected_values.size());
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin
      int taken;
      draw_request_type rq;

      // every input known from time zero
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.req_type   = REQ_RESEED;
      req_if.seed_value = '0;
      req_if.bit_count  = '0;
      req_if.bound      = '0;
      rsp_if.ready      = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: reset state first, then count extremes and every request kind
      pending_requests.push_back(make_request(REQ_NEXT_BITS, rand64(), 6'd32, 31'($urandom)));
      pending_requests.push_back(make_request(REQ_NEXT_BITS, rand64(), 6'd1, 31'($urandom)));
      // zero count still advances the state
      pending_requests.push_back(make_request(REQ_NEXT_BITS, rand64(), 6'd0, 31'($urandom)));
      // counts past 32 saturate
      pending_requests.push_back(make_request(REQ_NEXT_BITS, rand64(), 6'd63, 31'($urandom)));
      pending_requests.push_back(make_request(REQ_NEXT_BITS, rand64(), 6'd33, 31'($urandom)));
      pending_requests.push_back(make_request(REQ_FLOAT, rand64(), 6'($urandom), 31'($urandom)));
      pending_requests.push_back(make_request(REQ_DOUBLE, rand64(), 6'($urandom), 31'($urandom)));
      pending_requests.push_back(make_request(REQ_LONG, rand64(), 6'($urandom), 31'($urandom)));
      pending_requests.push_back(make_request(REQ_RESEED, '0, 6'($urandom), 31'($urandom)));
      pending_requests.push_back(make_request(REQ_NEXT_BITS, rand64(), 6'd32, 31'($urandom)));
      pending_requests.push_back(make_request(REQ_RESEED, 64'h8000_0000_0000_0000, 6'd0, '0));
      pending_requests.push_back(make_request(REQ_LONG, rand64(), 6'($urandom), 31'($urandom)));
      pending_requests.push_back(make_request(REQ_RESEED, '1, 6'h3F, '1));
      // bounded: powers of two at both ends, largest bound, zero, small, rejection-prone
      pending_requests.push_back(make_request(REQ_BOUNDED, rand64(), 6'($urandom), 31'd1));
      pending_requests.push_back(make_request(REQ_BOUNDED, rand64(), 6'($urandom),
                                              31'h4000_0000));
      pending_requests.push_back(make_request(REQ_BOUNDED, rand64(), 6'($urandom),
                                              31'h7FFF_FFFF));
      pending_requests.push_back(make_request(REQ_BOUNDED, rand64(), 6'($urandom), 31'd0));
      pending_requests.push_back(make_request(REQ_BOUNDED, rand64(), 6'($urandom), 31'd3));
      pending_requests.push_back(make_request(REQ_BOUNDED, rand64(), 6'($urandom),
                                              31'h4000_0001));
      pending_requests.push_back(make_request(REQ_BOUNDED, rand64(), 6'($urandom),
                                              31'h6000_0000));
      // unknown kinds leave the state alone and answer zero
      pending_requests.push_back(make_request(REQ_SPARE6, rand64(), 6'($urandom), 31'($urandom)));
      pending_requests.push_back(make_request(REQ_SPARE7, rand64(), 6'($urandom), 31'($urandom)));
      pending_requests.push_back(make_request(REQ_RESEED, 64'h7FFF_FFFF_FFFF_FFFF, '1, '1));
      pending_requests.push_back(make_request(REQ_DOUBLE, rand64(), 6'($urandom), 31'($urandom)));
      pending_requests.push_back(make_request(REQ_FLOAT, rand64(), 6'($urandom), 31'($urandom)));
      wait_for_drain();

      // random traffic with idling on both channels; ignored kinds do not count
      taken = 0;
      while (taken < BUSY_COUNT) begin
         rq = random_request();
         pending_requests.push_back(rq);
         if (rq.kind <= REQ_DOUBLE)
            taken++;
      end
      wait_for_drain();

      // closing stretch at full rate
      idling_on = 1'b0;
      taken = 0;
      while (taken < CALM_COUNT) begin
         rq = random_request();
         pending_requests.push_back(rq);
         if (rq.kind <= REQ_DOUBLE)
            taken++;
      end
      wait_for_drain();

      // catch any stray response after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);
      failures += expected_values.size();

      $write("requests: reseed %0d, next_bits %0d, bounded %0d, long %0d, ",
             kind_hits[REQ_RESEED], kind_hits[REQ_NEXT_BITS], kind_hits[REQ_BOUNDED],
             kind_hits[REQ_LONG]);
      $display("float %0d, double %0d, unknown %0d", kind_hits[REQ_FLOAT],
               kind_hits[REQ_DOUBLE], kind_hits[REQ_SPARE6] + kind_hits[REQ_SPARE7]);
      $display("responses checked: %0d, bounded redraws after rejection: %0d, failures: %0d",
               results_checked, redraws, failures);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
